// ----- hdl/mvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mvs_pkg;

    localparam int MAX_ITEMS_DEF   = 65536;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FRAC_BITS       = 8;
    localparam int OUT_W           = 48;
    localparam int WORK_W          = 64;
    localparam int WIDE_W          = 2 * WORK_W;
    localparam int THR_W           = 16;
    localparam int MODE_W          = 2;
    localparam int CFG_W           = 16;
    localparam int CFG_ADDR_W      = 1;
    localparam int Q_W             = 16;
    localparam int STEP_W          = 6;
    localparam int MISSING_CODE    = -256;

    localparam logic [CFG_ADDR_W-1:0] REG_METRIC_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 1'd1;

    localparam logic [STEP_W-1:0] MUL_LAST  = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'd63;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd15;

    localparam logic [WORK_W-1:0] OUT_MAX      = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [WORK_W-1:0] MANH_LIMIT   = OUT_MAX >> FRAC_BITS;
    localparam logic [OUT_W-1:0]  METRIC_UNDEF = 48'hFFFF_FFFF_0000;
    localparam logic [Q_W:0]      ONE_Q        = 17'h10000;

    typedef enum logic [1:0] {
        MODE_COSINE    = 2'd0,
        MODE_PEARSON   = 2'd1,
        MODE_MANHATTAN = 2'd2,
        MODE_EUCLIDEAN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        SEL_XX_YY = 3'd0,
        SEL_N_XX  = 3'd1,
        SEL_X_X   = 3'd2,
        SEL_N_YY  = 3'd3,
        SEL_Y_Y   = 3'd4,
        SEL_N_XY  = 3'd5,
        SEL_X_Y   = 3'd6,
        SEL_VA_VB = 3'd7
    } mul_sel_t;

    typedef enum logic [1:0] {
        KIND_UNDEF = 2'd0,
        KIND_RATIO = 2'd1,
        KIND_MANH  = 2'd2,
        KIND_EUCL  = 2'd3
    } out_kind_t;

    typedef enum logic [3:0] {
        ST_ACCUM    = 4'd0,
        ST_DISPATCH = 4'd1,
        ST_MUL_LOAD = 4'd2,
        ST_MUL_RUN  = 4'd3,
        ST_MUL_DONE = 4'd4,
        ST_CHECK    = 4'd5,
        ST_SQRT_RUN = 4'd6,
        ST_DIV_LOAD = 4'd7,
        ST_DIV_RUN  = 4'd8,
        ST_OUT      = 4'd9
    } state_t;

    typedef struct packed {
        logic      acc_en;
        logic      clear;
        logic      mul_load;
        logic      mul_step;
        logic      mul_commit;
        mul_sel_t  sel;
        logic      rad_load_ssd;
        logic      sqrt_step;
        logic      div_load;
        logic      div_step;
        logic      out_load;
        out_kind_t kind;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  n_zero;
        logic  sxx_zero;
        logic  syy_zero;
        logic  va_zero;
        logic  vb_zero;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/mvs_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle while step is high.
module mvs_mul (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic                          step,
    input  wire logic [mvs_pkg::WORK_W-1:0]    op_a,
    input  wire logic [mvs_pkg::WORK_W-1:0]    op_b,
    output logic      [mvs_pkg::WIDE_W-1:0]    product
);
    localparam int W = mvs_pkg::WORK_W;

    logic [W-1:0] hi_reg, hi_next;
    logic [W-1:0] lo_reg, lo_next;
    logic [W-1:0] mcand_reg, mcand_next;
    logic [W:0]   sum;

    always_comb begin
        sum        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : {(W+1){1'b0}});
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        if (load) begin
            hi_next    = '0;
            lo_next    = op_b;
            mcand_next = op_a;
        end else if (step) begin
            hi_next = sum[W:1];
            lo_next = {sum[0], lo_reg[W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ----- hdl/mvs_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle while step is high.
module mvs_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic                          step,
    input  wire logic [mvs_pkg::WIDE_W-1:0]    radicand,
    output logic      [mvs_pkg::WORK_W-1:0]    root
);
    localparam int W  = mvs_pkg::WORK_W;
    localparam int WW = mvs_pkg::WIDE_W;
    localparam int RW = W + 1;

    logic [WW-1:0] rad_reg, rad_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [W-1:0]  root_reg, root_next;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[WW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (load) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (step) begin
            rad_next = {rad_reg[WW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = RW'(rem_sh - trial);
                root_next = {root_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[RW-1:0];
                root_next = {root_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// ----- hdl/mvs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Datapath: registers, accumulators, work terms, divider and result register.
module mvs_dp #(
    parameter int MAX_ITEMS   = mvs_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mvs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mvs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [mvs_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic signed [VALUE_WIDTH-1:0]     first_value,
    input  wire logic signed [VALUE_WIDTH-1:0]     second_value,
    input  wire mvs_pkg::cmd_t                     cmd,
    output mvs_pkg::status_t                       status,
    output logic [mvs_pkg::OUT_W-1:0]              metric,
    output logic                                   undefined
);
    localparam int VW    = VALUE_WIDTH;
    localparam int W     = mvs_pkg::WORK_W;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = (VW + CNT_W > W) ? W : VW + CNT_W;
    localparam int SQ_W  = (2 * VW + CNT_W > W) ? W : 2 * VW + CNT_W;
    localparam int CMP_W = ((VW > mvs_pkg::THR_W) ? VW : mvs_pkg::THR_W) + 1;
    localparam int QW    = mvs_pkg::Q_W;
    localparam int OW    = mvs_pkg::OUT_W;

    mvs_pkg::mode_t                 mode_reg;
    logic signed [mvs_pkg::THR_W-1:0] thr_reg;

    logic        [CNT_W-1:0]  cnt_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic signed [SQ_W-1:0]   sxy_reg;
    logic        [SQ_W-1:0]   sxx_reg, syy_reg;
    logic        [SUM_W-1:0]  sad_reg;
    logic        [SQ_W-1:0]   ssd_reg;

    logic signed [CMP_W-1:0]  a_c, b_c, th_c, miss_c;
    logic signed [VW:0]       diff;
    logic        [VW-1:0]     ad;
    logic signed [2*VW-1:0]   p_ab, p_aa, p_bb;
    logic        [2*VW-1:0]   p_dd;
    logic                     take;

    logic [W-1:0] sx64, sy64, sxy64, sxx64, syy64, n64, ssd64, sad64;
    logic [W-1:0] va_reg, vb_reg, num_reg;
    logic [W-1:0] op_a, op_b;
    logic [mvs_pkg::WIDE_W-1:0] product, radicand;
    logic [W-1:0] root, dvs, mag;
    logic         rad_load;

    logic [W-1:0]  drem_reg;
    logic [W:0]    drem_sh;
    logic [QW-1:0] q_reg;
    logic          sat_reg, neg_reg;
    logic [QW:0]   q_mag;
    logic [OW-1:0] ratio, metric_reg, metric_next;
    logic          undef_reg, undef_next;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mvs_pkg::MODE_COSINE;
            thr_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mvs_pkg::REG_METRIC_MODE:
                    mode_reg <= mvs_pkg::mode_t'(cfg_wdata[mvs_pkg::MODE_W-1:0]);
                mvs_pkg::REG_THRESHOLD:
                    thr_reg  <= $signed(cfg_wdata[mvs_pkg::THR_W-1:0]);
            endcase
        end
    end

    // Pair qualification and per-pair terms
    always_comb begin
        a_c    = CMP_W'(first_value);
        b_c    = CMP_W'(second_value);
        th_c   = CMP_W'(thr_reg);
        miss_c = CMP_W'(mvs_pkg::MISSING_CODE);
        take   = cmd.acc_en && (a_c != miss_c) && (b_c != miss_c)
                 && (a_c > th_c) && (b_c > th_c)
                 && (cnt_reg < CNT_W'(MAX_ITEMS));
        diff   = (VW+1)'(first_value) - (VW+1)'(second_value);
        ad     = diff[VW] ? VW'(-diff) : diff[VW-1:0];
        p_ab   = first_value * second_value;
        p_aa   = first_value * first_value;
        p_bb   = second_value * second_value;
        p_dd   = ad * ad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sad_reg <= '0;
            ssd_reg <= '0;
        end else if (take) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            sx_reg  <= sx_reg + SUM_W'(first_value);
            sy_reg  <= sy_reg + SUM_W'(second_value);
            sxy_reg <= sxy_reg + SQ_W'(p_ab);
            sxx_reg <= sxx_reg + SQ_W'($unsigned(p_aa));
            syy_reg <= syy_reg + SQ_W'($unsigned(p_bb));
            sad_reg <= sad_reg + SUM_W'(ad);
            ssd_reg <= ssd_reg + SQ_W'(p_dd);
        end
    end

    // Sums seen as 64-bit two's complement words
    always_comb begin
        sx64  = W'(sx_reg);
        sy64  = W'(sy_reg);
        sxy64 = W'(sxy_reg);
        sxx64 = W'(sxx_reg);
        syy64 = W'(syy_reg);
        n64   = W'(cnt_reg);
        sad64 = W'(sad_reg);
        ssd64 = W'(ssd_reg);
        unique case (cmd.sel)
            mvs_pkg::SEL_XX_YY: begin op_a = sxx64;  op_b = syy64;  end
            mvs_pkg::SEL_N_XX:  begin op_a = n64;    op_b = sxx64;  end
            mvs_pkg::SEL_X_X:   begin op_a = sx64;   op_b = sx64;   end
            mvs_pkg::SEL_N_YY:  begin op_a = n64;    op_b = syy64;  end
            mvs_pkg::SEL_Y_Y:   begin op_a = sy64;   op_b = sy64;   end
            mvs_pkg::SEL_N_XY:  begin op_a = n64;    op_b = sxy64;  end
            mvs_pkg::SEL_X_Y:   begin op_a = sx64;   op_b = sy64;   end
            mvs_pkg::SEL_VA_VB: begin op_a = va_reg; op_b = vb_reg; end
        endcase
    end

    mvs_mul u_mul (
        .aclk    (aclk),
        .load    (cmd.mul_load),
        .step    (cmd.mul_step),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // Commit a finished product; low words wrap modulo 2^64 (XX*YY and VA*VB go to the root instead)
    always_ff @(posedge aclk) begin
        if (cmd.mul_commit) begin
            unique case (cmd.sel)
                mvs_pkg::SEL_XX_YY: num_reg <= sxy64;
                mvs_pkg::SEL_N_XX:  va_reg  <= product[W-1:0];
                mvs_pkg::SEL_X_X:   va_reg  <= va_reg - product[W-1:0];
                mvs_pkg::SEL_N_YY:  vb_reg  <= product[W-1:0];
                mvs_pkg::SEL_Y_Y:   vb_reg  <= vb_reg - product[W-1:0];
                mvs_pkg::SEL_N_XY:  num_reg <= product[W-1:0];
                mvs_pkg::SEL_X_Y:   num_reg <= num_reg - product[W-1:0];
                mvs_pkg::SEL_VA_VB: num_reg <= num_reg;
            endcase
        end
    end

    assign rad_load = cmd.rad_load_ssd || (cmd.mul_commit &&
                      (cmd.sel == mvs_pkg::SEL_XX_YY || cmd.sel == mvs_pkg::SEL_VA_VB));
    assign radicand = cmd.rad_load_ssd ? {48'd0, ssd64, 16'd0} : product;

    mvs_sqrt u_sqrt (
        .aclk     (aclk),
        .load     (rad_load),
        .step     (cmd.sqrt_step),
        .radicand (radicand),
        .root     (root)
    );

    // Fractional divide: q = min(floor(mag * 2^16 / dvs), 1.0)
    assign dvs     = (root == '0) ? W'(1) : root;
    assign mag     = num_reg[W-1] ? W'(-num_reg) : num_reg;
    assign drem_sh = {drem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            drem_reg <= mag;
            sat_reg  <= (mag >= dvs);
            neg_reg  <= num_reg[W-1];
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            if (drem_sh >= {1'b0, dvs}) begin
                drem_reg <= W'(drem_sh - {1'b0, dvs});
                q_reg    <= {q_reg[QW-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh[W-1:0];
                q_reg    <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign q_mag = sat_reg ? mvs_pkg::ONE_Q : {1'b0, q_reg};
    assign ratio = neg_reg ? -OW'(q_mag) : OW'(q_mag);

    always_comb begin
        metric_next = metric_reg;
        undef_next  = undef_reg;
        if (cmd.out_load) begin
            undef_next = 1'b0;
            unique case (cmd.kind)
                mvs_pkg::KIND_UNDEF: begin
                    metric_next = mvs_pkg::METRIC_UNDEF;
                    undef_next  = 1'b1;
                end
                mvs_pkg::KIND_RATIO: metric_next = ratio;
                mvs_pkg::KIND_MANH:
                    metric_next = (sad64 > mvs_pkg::MANH_LIMIT) ? mvs_pkg::OUT_MAX[OW-1:0]
                                  : OW'(sad64 << mvs_pkg::FRAC_BITS);
                mvs_pkg::KIND_EUCL:
                    metric_next = (root > mvs_pkg::OUT_MAX) ? mvs_pkg::OUT_MAX[OW-1:0]
                                  : root[OW-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        metric_reg <= metric_next;
        undef_reg  <= undef_next;
    end

    assign metric    = metric_reg;
    assign undefined = undef_reg;

    assign status.mode     = mode_reg;
    assign status.n_zero   = (cnt_reg == '0);
    assign status.sxx_zero = (sxx_reg == '0);
    assign status.syy_zero = (syy_reg == '0);
    assign status.va_zero  = (va_reg == '0);
    assign status.vb_zero  = (vb_reg == '0);

endmodule

`default_nettype wire

// ----- hdl/mvs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: accumulate beats, then step the multiply, root and divide work.
module mvs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    input  wire logic             m_tready,
    input  wire mvs_pkg::status_t status,
    output logic                  s_tready,
    output logic                  m_tvalid,
    output mvs_pkg::cmd_t         cmd
);
    mvs_pkg::state_t    state_reg, state_next;
    logic [mvs_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    mvs_pkg::mul_sel_t  sel_reg, sel_next;
    mvs_pkg::out_kind_t kind_reg, kind_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        kind_next    = kind_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        unique case (state_reg)
            mvs_pkg::ST_ACCUM:
                if (s_tvalid && s_tlast) state_next = mvs_pkg::ST_DISPATCH;
            mvs_pkg::ST_DISPATCH: begin
                unique case (status.mode)
                    mvs_pkg::MODE_COSINE: begin
                        if (status.sxx_zero || status.syy_zero) begin
                            kind_next  = mvs_pkg::KIND_UNDEF;
                            state_next = mvs_pkg::ST_OUT;
                        end else begin
                            kind_next  = mvs_pkg::KIND_RATIO;
                            sel_next   = mvs_pkg::SEL_XX_YY;
                            state_next = mvs_pkg::ST_MUL_LOAD;
                        end
                    end
                    mvs_pkg::MODE_PEARSON: begin
                        if (status.n_zero) begin
                            kind_next  = mvs_pkg::KIND_UNDEF;
                            state_next = mvs_pkg::ST_OUT;
                        end else begin
                            kind_next  = mvs_pkg::KIND_RATIO;
                            sel_next   = mvs_pkg::SEL_N_XX;
                            state_next = mvs_pkg::ST_MUL_LOAD;
                        end
                    end
                    mvs_pkg::MODE_MANHATTAN: begin
                        kind_next  = mvs_pkg::KIND_MANH;
                        state_next = mvs_pkg::ST_OUT;
                    end
                    mvs_pkg::MODE_EUCLIDEAN: begin
                        kind_next  = mvs_pkg::KIND_EUCL;
                        cnt_next   = mvs_pkg::SQRT_LAST;
                        state_next = mvs_pkg::ST_SQRT_RUN;
                    end
                endcase
            end
            mvs_pkg::ST_MUL_LOAD: begin
                cnt_next   = mvs_pkg::MUL_LAST;
                state_next = mvs_pkg::ST_MUL_RUN;
            end
            mvs_pkg::ST_MUL_RUN: begin
                if (cnt_reg == '0) state_next = mvs_pkg::ST_MUL_DONE;
                else               cnt_next   = cnt_reg - mvs_pkg::STEP_W'(1);
            end
            mvs_pkg::ST_MUL_DONE: begin
                state_next = mvs_pkg::ST_MUL_LOAD;
                unique case (sel_reg)
                    mvs_pkg::SEL_XX_YY, mvs_pkg::SEL_VA_VB: begin
                        cnt_next   = mvs_pkg::SQRT_LAST;
                        state_next = mvs_pkg::ST_SQRT_RUN;
                    end
                    mvs_pkg::SEL_N_XX: sel_next   = mvs_pkg::SEL_X_X;
                    mvs_pkg::SEL_X_X:  sel_next   = mvs_pkg::SEL_N_YY;
                    mvs_pkg::SEL_N_YY: sel_next   = mvs_pkg::SEL_Y_Y;
                    mvs_pkg::SEL_Y_Y:  state_next = mvs_pkg::ST_CHECK;
                    mvs_pkg::SEL_N_XY: sel_next   = mvs_pkg::SEL_X_Y;
                    mvs_pkg::SEL_X_Y:  sel_next   = mvs_pkg::SEL_VA_VB;
                endcase
            end
            mvs_pkg::ST_CHECK: begin
                if (status.va_zero || status.vb_zero) begin
                    kind_next  = mvs_pkg::KIND_UNDEF;
                    state_next = mvs_pkg::ST_OUT;
                end else begin
                    sel_next   = mvs_pkg::SEL_N_XY;
                    state_next = mvs_pkg::ST_MUL_LOAD;
                end
            end
            mvs_pkg::ST_SQRT_RUN: begin
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - mvs_pkg::STEP_W'(1);
                else if (kind_reg == mvs_pkg::KIND_EUCL)
                    state_next = mvs_pkg::ST_OUT;
                else
                    state_next = mvs_pkg::ST_DIV_LOAD;
            end
            mvs_pkg::ST_DIV_LOAD: begin
                cnt_next   = mvs_pkg::DIV_LAST;
                state_next = mvs_pkg::ST_DIV_RUN;
            end
            mvs_pkg::ST_DIV_RUN: begin
                if (cnt_reg == '0) state_next = mvs_pkg::ST_OUT;
                else               cnt_next   = cnt_reg - mvs_pkg::STEP_W'(1);
            end
            mvs_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = mvs_pkg::ST_ACCUM;
                end
            end
            default: state_next = mvs_pkg::ST_ACCUM;
        endcase
    end

    always_comb begin
        cmd              = '0;
        cmd.sel          = sel_reg;
        cmd.kind         = kind_reg;
        s_tready         = (state_reg == mvs_pkg::ST_ACCUM);
        m_tvalid         = m_valid_reg;
        cmd.acc_en       = s_tready && s_tvalid;
        cmd.mul_load     = (state_reg == mvs_pkg::ST_MUL_LOAD);
        cmd.mul_step     = (state_reg == mvs_pkg::ST_MUL_RUN);
        cmd.mul_commit   = (state_reg == mvs_pkg::ST_MUL_DONE);
        cmd.rad_load_ssd = (state_reg == mvs_pkg::ST_DISPATCH)
                           && (status.mode == mvs_pkg::MODE_EUCLIDEAN);
        cmd.sqrt_step    = (state_reg == mvs_pkg::ST_SQRT_RUN);
        cmd.div_load     = (state_reg == mvs_pkg::ST_DIV_LOAD);
        cmd.div_step     = (state_reg == mvs_pkg::ST_DIV_RUN);
        cmd.out_load     = (state_reg == mvs_pkg::ST_OUT) && out_free;
        cmd.clear        = cmd.out_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mvs_pkg::ST_ACCUM;
            cnt_reg     <= '0;
            sel_reg     <= mvs_pkg::SEL_XX_YY;
            kind_reg    <= mvs_pkg::KIND_UNDEF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/masked_vector_similarity.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// cfg_*     in         register write: cfg_addr 0 metric_mode, 1 threshold
// s_axis    in         one element pair; tlast closes the vector pair
// m_axis    out        one metric per vector pair, tuser flags the -1.0 sentinel
//
// Pair beats are taken one per cycle while s_tready is high. After the tlast
// beat s_tready drops while the result is worked out: manhattan goes straight
// to the output, euclidean runs the 64-step root, cosine and pearson the
// shift-add multiply (load, 64 steps, commit), 64-step root and 16-step divide.
// Reset (aresetn low, synchronous) clears config, accumulators and control state.
// A waiting result does not block new pair beats; a finished result holds
// in the controller until the output register frees.
module masked_vector_similarity #(
    parameter int MAX_ITEMS   = mvs_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mvs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mvs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mvs_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // first_value, second_value, zero pad
    input  wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // metric
    output logic [mvs_pkg::OUT_W-1:0]           m_tdata,
    // undefined
    output logic [0:0]                          m_tuser
);
    mvs_pkg::cmd_t    cmd;
    mvs_pkg::status_t status;
    logic             undef;

    // Unpack the pair beat
    logic signed [VALUE_WIDTH-1:0] first_value;
    logic signed [VALUE_WIDTH-1:0] second_value;

    assign first_value  = $signed(s_tdata[VALUE_WIDTH-1:0]);
    assign second_value = $signed(s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);

    mvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    mvs_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .first_value  (first_value),
        .second_value (second_value),
        .cmd          (cmd),
        .status       (status),
        .metric       (m_tdata),
        .undefined    (undef)
    );

    assign m_tuser = undef;

    // A tlast beat starts the result work: no pair beat is taken next cycle.
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("pair beat taken right after tlast");

    // The sentinel flag always travels with -1.0.
    a_undef_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == mvs_pkg::METRIC_UNDEF)
        else $error("undefined flag without -1.0 metric");

    // Only cosine and pearson raise the sentinel.
    a_undef_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            status.mode == mvs_pkg::MODE_COSINE || status.mode == mvs_pkg::MODE_PEARSON)
        else $error("undefined flag in a distance mode");

    // Ratios stay within plus or minus one.
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] &&
        (status.mode == mvs_pkg::MODE_COSINE || status.mode == mvs_pkg::MODE_PEARSON) |->
            $signed(m_tdata) <= 48'sd65536 && $signed(m_tdata) >= -48'sd65536)
        else $error("ratio out of range");

endmodule

`default_nettype wire
